// File: rtl/core/c8ab_pkg.sv
// Shared types and constants for the CHIP-8 ALU/branch unit.
// No dependencies; every rtl/core module but c8ab_ram refers to it by scoped names.
package c8ab_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);  // holds 0..STACK_DEPTH
    localparam int SA_W        = $clog2(STACK_DEPTH);      // stack RAM address
    localparam int PC_W        = 12;
    localparam int BYTE_W      = 8;
    localparam int REG_NUM     = 16;
    localparam int RIDX_W      = 4;

    localparam logic [RIDX_W-1:0] FLAG_IDX = 4'hF;

    typedef enum logic [3:0] {
        OP_RET   = 4'd0,
        OP_JMP   = 4'd1,
        OP_CALL  = 4'd2,
        OP_SKEQI = 4'd3,
        OP_SKNEI = 4'd4,
        OP_SKEQR = 4'd5,
        OP_SETI  = 4'd6,
        OP_ADDI  = 4'd7,
        OP_MOV   = 4'd8,
        OP_OR    = 4'd9,
        OP_AND   = 4'd10,
        OP_XOR   = 4'd11,
        OP_ADDC  = 4'd12,
        OP_SUB   = 4'd13,
        OP_SUBN  = 4'd14,
        OP_SKNER = 4'd15
    } op_t;

    // register file write-back, issued when the word that was read retires
    typedef struct packed {
        logic                  we;
        logic [RIDX_W-1:0]     addr;
        logic [BYTE_W-1:0]     data;
        logic                  flag_we;
        logic [BYTE_W-1:0]     flag_data;
    } rf_wr_t;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [PC_W-1:0]       data;
    } stk_ctl_t;

    typedef struct packed {
        logic                  empty;
        logic                  full;
        logic [PC_W-1:0]       top;
    } stk_stat_t;

    typedef struct packed {
        op_t                   op;
        logic [RIDX_W-1:0]     x;
        logic [PC_W-1:0]       imm;
        logic [BYTE_W-1:0]     vx;
        logic [BYTE_W-1:0]     vy;
        logic [BYTE_W-1:0]     vf;
        logic [PC_W-1:0]       pc;
        stk_stat_t             stk;
    } exec_in_t;

    typedef struct packed {
        logic [PC_W-1:0]       pc_next;
        logic                  reg_we;      // write Vx in the RAM (x is not VF)
        logic [BYTE_W-1:0]     x_value;     // Vx after the instruction
        logic                  flag_we;
        logic [BYTE_W-1:0]     flag_value;  // VF after the instruction
        logic                  push;
        logic                  pop;
        logic                  fault;
    } exec_out_t;

endpackage

// File: rtl/core/c8ab_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; no dependencies.
module c8ab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/c8ab_regfile.sv
// V0..V14 in two RAM copies (one per read port), VF in a flop.
// Valid bits give reset-to-zero; a one-entry bypass covers read-during-write.
// Depends on c8ab_pkg and c8ab_ram.
module c8ab_regfile (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rd_en,
    input  logic [c8ab_pkg::RIDX_W-1:0]       rd_x,
    input  logic [c8ab_pkg::RIDX_W-1:0]       rd_y,
    input  c8ab_pkg::rf_wr_t                  wr,
    output logic [c8ab_pkg::BYTE_W-1:0]       vx,
    output logic [c8ab_pkg::BYTE_W-1:0]       vy,
    output logic [c8ab_pkg::BYTE_W-1:0]       vf
);

    logic [c8ab_pkg::BYTE_W-1:0]  ram_x;
    logic [c8ab_pkg::BYTE_W-1:0]  ram_y;
    logic [c8ab_pkg::RIDX_W-1:0]  rx_reg;
    logic [c8ab_pkg::RIDX_W-1:0]  ry_reg;
    logic                         hit_x_reg;
    logic                         hit_y_reg;
    logic [c8ab_pkg::BYTE_W-1:0]  byp_data_reg;
    logic [c8ab_pkg::REG_NUM-1:0] valid_reg;
    logic [c8ab_pkg::BYTE_W-1:0]  flag_reg;

    c8ab_ram #(
        .WIDTH (c8ab_pkg::BYTE_W),
        .DEPTH (c8ab_pkg::REG_NUM)
    ) u_ram_x (
        .aclk    (aclk),
        .wr_en   (wr.we),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_x),
        .rd_data (ram_x)
    );

    c8ab_ram #(
        .WIDTH (c8ab_pkg::BYTE_W),
        .DEPTH (c8ab_pkg::REG_NUM)
    ) u_ram_y (
        .aclk    (aclk),
        .wr_en   (wr.we),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_y),
        .rd_data (ram_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            flag_reg  <= '0;
        end else begin
            if (wr.we) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (wr.flag_we) begin
                flag_reg <= wr.flag_data;
            end
        end
    end

    // capture a write landing on the same edge as the read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rx_reg       <= rd_x;
            ry_reg       <= rd_y;
            hit_x_reg    <= wr.we && (wr.addr == rd_x);
            hit_y_reg    <= wr.we && (wr.addr == rd_y);
            byp_data_reg <= wr.data;
        end
    end

    always_comb begin
        if (rx_reg == c8ab_pkg::FLAG_IDX) begin
            vx = flag_reg;
        end else if (hit_x_reg) begin
            vx = byp_data_reg;
        end else if (valid_reg[rx_reg]) begin
            vx = ram_x;
        end else begin
            vx = '0;
        end
    end

    always_comb begin
        if (ry_reg == c8ab_pkg::FLAG_IDX) begin
            vy = flag_reg;
        end else if (hit_y_reg) begin
            vy = byp_data_reg;
        end else if (valid_reg[ry_reg]) begin
            vy = ram_y;
        end else begin
            vy = '0;
        end
    end

    assign vf = flag_reg;

endmodule

// File: rtl/core/c8ab_stack.sv
// Return stack: RAM of return addresses plus the depth counter.
// Top entry is prefetched on accept; push-then-pop on adjacent words bypasses.
// Depends on c8ab_pkg and c8ab_ram.
module c8ab_stack (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  rd_en,
    input  c8ab_pkg::stk_ctl_t    ctl,
    output c8ab_pkg::stk_stat_t   stat
);

    logic [c8ab_pkg::SP_W-1:0] depth_reg;
    logic [c8ab_pkg::SP_W-1:0] depth_next;
    logic [c8ab_pkg::SA_W-1:0] wr_addr;
    logic [c8ab_pkg::SA_W-1:0] rd_addr;
    logic [c8ab_pkg::PC_W-1:0] ram_data;
    logic                      hit_reg;
    logic [c8ab_pkg::PC_W-1:0] byp_data_reg;

    always_comb begin
        depth_next = depth_reg;
        if (ctl.push) begin
            depth_next = depth_reg + c8ab_pkg::SP_W'(1);
        end else if (ctl.pop) begin
            depth_next = depth_reg - c8ab_pkg::SP_W'(1);
        end
    end

    assign wr_addr = depth_reg[c8ab_pkg::SA_W-1:0];
    // top after the current word retires; meaningless when the stack goes empty
    assign rd_addr = c8ab_pkg::SA_W'(depth_next - c8ab_pkg::SP_W'(1));

    c8ab_ram #(
        .WIDTH (c8ab_pkg::PC_W),
        .DEPTH (c8ab_pkg::STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ctl.push),
        .wr_addr (wr_addr),
        .wr_data (ctl.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hit_reg      <= ctl.push && (wr_addr == rd_addr);
            byp_data_reg <= ctl.data;
        end
    end

    assign stat.empty = (depth_reg == '0);
    assign stat.full  = (depth_reg == c8ab_pkg::SP_W'(c8ab_pkg::STACK_DEPTH));
    assign stat.top   = hit_reg ? byp_data_reg : ram_data;

endmodule

// File: rtl/core/c8ab_exec.sv
// Execute logic: ALU, skip compare, branch target and stack control.
// Purely combinational; depends on c8ab_pkg.
module c8ab_exec (
    input  c8ab_pkg::exec_in_t   ex_in,
    output c8ab_pkg::exec_out_t  ex_out
);

    logic [c8ab_pkg::BYTE_W-1:0] nn;
    logic [c8ab_pkg::BYTE_W:0]   sum;
    logic [c8ab_pkg::PC_W-1:0]   pc_tgt;
    logic [c8ab_pkg::BYTE_W-1:0] res;
    logic                        wr;
    logic                        fset;
    logic                        fbit;
    logic                        skip;
    logic                        x_is_f;
    logic                        push;
    logic                        pop;
    logic                        fault;
    logic [c8ab_pkg::BYTE_W-1:0] flag_val;

    assign nn  = ex_in.imm[c8ab_pkg::BYTE_W-1:0];
    assign sum = {1'b0, ex_in.vx} + {1'b0, ex_in.vy};

    always_comb begin
        pc_tgt = ex_in.pc;
        res    = ex_in.vx;
        wr     = 1'b0;
        fset   = 1'b0;
        fbit   = 1'b0;
        skip   = 1'b0;
        push   = 1'b0;
        pop    = 1'b0;
        fault  = 1'b0;
        unique case (ex_in.op)
            c8ab_pkg::OP_RET: begin
                if (ex_in.stk.empty) begin
                    fault = 1'b1;
                end else begin
                    pop    = 1'b1;
                    pc_tgt = ex_in.stk.top;
                end
            end
            c8ab_pkg::OP_JMP: pc_tgt = ex_in.imm;
            c8ab_pkg::OP_CALL: begin
                if (ex_in.stk.full) begin
                    fault = 1'b1;
                end else begin
                    push   = 1'b1;
                    pc_tgt = ex_in.imm;
                end
            end
            c8ab_pkg::OP_SKEQI: skip = (ex_in.vx == nn);
            c8ab_pkg::OP_SKNEI: skip = (ex_in.vx != nn);
            c8ab_pkg::OP_SKEQR: skip = (ex_in.vx == ex_in.vy);
            c8ab_pkg::OP_SKNER: skip = (ex_in.vx != ex_in.vy);
            c8ab_pkg::OP_SETI: begin
                res = nn;
                wr  = 1'b1;
            end
            c8ab_pkg::OP_ADDI: begin
                res = ex_in.vx + nn;
                wr  = 1'b1;
            end
            c8ab_pkg::OP_MOV: begin
                res = ex_in.vy;
                wr  = 1'b1;
            end
            c8ab_pkg::OP_OR: begin
                res = ex_in.vx | ex_in.vy;
                wr  = 1'b1;
            end
            c8ab_pkg::OP_AND: begin
                res = ex_in.vx & ex_in.vy;
                wr  = 1'b1;
            end
            c8ab_pkg::OP_XOR: begin
                res = ex_in.vx ^ ex_in.vy;
                wr  = 1'b1;
            end
            c8ab_pkg::OP_ADDC: begin
                res  = sum[c8ab_pkg::BYTE_W-1:0];
                wr   = 1'b1;
                fset = 1'b1;
                fbit = sum[c8ab_pkg::BYTE_W];
            end
            c8ab_pkg::OP_SUB: begin
                res  = ex_in.vx - ex_in.vy;
                wr   = 1'b1;
                fset = 1'b1;
                fbit = (ex_in.vx >= ex_in.vy);
            end
            c8ab_pkg::OP_SUBN: begin
                res  = ex_in.vy - ex_in.vx;
                wr   = 1'b1;
                fset = 1'b1;
                fbit = (ex_in.vy >= ex_in.vx);
            end
        endcase
    end

    // result into VF overrides the flag
    assign x_is_f = (ex_in.x == c8ab_pkg::FLAG_IDX);

    always_comb begin
        if (wr && x_is_f) begin
            flag_val = res;
        end else if (fset) begin
            flag_val = {{(c8ab_pkg::BYTE_W-1){1'b0}}, fbit};
        end else begin
            flag_val = ex_in.vf;
        end
    end

    assign ex_out.pc_next    = skip ? (ex_in.pc + c8ab_pkg::PC_W'(2)) : pc_tgt;
    assign ex_out.reg_we     = wr && !x_is_f;
    assign ex_out.x_value    = wr ? res : ex_in.vx;
    assign ex_out.flag_we    = fset || (wr && x_is_f);
    assign ex_out.flag_value = flag_val;
    assign ex_out.push       = push;
    assign ex_out.pop        = pop;
    assign ex_out.fault      = fault;

endmodule

// File: rtl/core/chip8_alu_branch_unit.sv
// CHIP-8 ALU and branch unit: executes one decoded instruction per input word
// (return, jump, call, the skips, immediate set/add, move, logic ops, add with
// carry and both subtracts) and returns pc, Vx, VF and a stack fault flag.
// Throughput is one word per clock while m_tready keeps the output register free;
// a word is held in stage 1 and then in the output register, which drives m_tvalid.
// V0..V14 and the return stack live in synchronous RAMs that
// are read on the accept edge; the word executes in stage 1 and writes
// back on the edge it moves into the output register. That read-execute-write
// loop through one RAM write port per store, closed by a one-entry bypass,
// sets the one-word-per-clock rate. The output register lets a new word in
// while a finished result waits on m_tready. Reset needs no clearing pass:
// register-file valid bits make unwritten registers read as zero.
// Depends on c8ab_pkg, c8ab_regfile, c8ab_stack, c8ab_exec.
module chip8_alu_branch_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[3:0], reg_x[7:4], reg_y[11:8], imm[23:12]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // pc_value[11:0], x_value[19:12],
                                   // flag_value[27:20], stack_fault[28], zero above
);

    // ---- handshake ----
    logic accept;
    logic fire;       // stage 1 word executes and retires into output reg

    // ---- stage 1 (RAM read data arrives here) ----
    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    c8ab_pkg::op_t                    s1_op_reg;
    logic [c8ab_pkg::RIDX_W-1:0]      s1_x_reg;
    logic [c8ab_pkg::PC_W-1:0]        s1_imm_reg;

    // ---- architectural pc ----
    logic [c8ab_pkg::PC_W-1:0]        pc_reg;
    logic [c8ab_pkg::PC_W-1:0]        pc_next;

    // ---- output register ----
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [c8ab_pkg::PC_W-1:0]        out_pc_reg;
    logic [c8ab_pkg::BYTE_W-1:0]      out_x_reg;
    logic [c8ab_pkg::BYTE_W-1:0]      out_flag_reg;
    logic                             out_fault_reg;

    // ---- datapath ----
    logic [c8ab_pkg::BYTE_W-1:0]      vx;
    logic [c8ab_pkg::BYTE_W-1:0]      vy;
    logic [c8ab_pkg::BYTE_W-1:0]      vf;
    c8ab_pkg::rf_wr_t                 rf_wr;
    c8ab_pkg::stk_ctl_t               stk_ctl;
    c8ab_pkg::stk_stat_t              stk_stat;
    c8ab_pkg::exec_in_t               ex_in;
    c8ab_pkg::exec_out_t              ex_out;

    assign fire     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign s1_valid_next  = accept || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    // register file: read Vx/Vy on accept, write back when stage 1 retires
    assign rf_wr.we        = fire && ex_out.reg_we;
    assign rf_wr.addr      = s1_x_reg;
    assign rf_wr.data      = ex_out.x_value;
    assign rf_wr.flag_we   = fire && ex_out.flag_we;
    assign rf_wr.flag_data = ex_out.flag_value;

    c8ab_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_x    (s_tdata[7:4]),
        .rd_y    (s_tdata[11:8]),
        .wr      (rf_wr),
        .vx      (vx),
        .vy      (vy),
        .vf      (vf)
    );

    // return stack: a call pushes the pc it found
    assign stk_ctl.push = fire && ex_out.push;
    assign stk_ctl.pop  = fire && ex_out.pop;
    assign stk_ctl.data = pc_reg;

    c8ab_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .ctl     (stk_ctl),
        .stat    (stk_stat)
    );

    assign ex_in.op  = s1_op_reg;
    assign ex_in.x   = s1_x_reg;
    assign ex_in.imm = s1_imm_reg;
    assign ex_in.vx  = vx;
    assign ex_in.vy  = vy;
    assign ex_in.vf  = vf;
    assign ex_in.pc  = pc_reg;
    assign ex_in.stk = stk_stat;

    c8ab_exec u_exec (
        .ex_in  (ex_in),
        .ex_out (ex_out)
    );

    assign pc_next = fire ? ex_out.pc_next : pc_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            pc_reg        <= pc_next;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg  <= c8ab_pkg::op_t'(s_tdata[3:0]);
            s1_x_reg   <= s_tdata[7:4];
            s1_imm_reg <= s_tdata[23:12];
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_pc_reg    <= ex_out.pc_next;
            out_x_reg     <= ex_out.x_value;
            out_flag_reg  <= ex_out.flag_value;
            out_fault_reg <= ex_out.fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_fault_reg, out_flag_reg, out_x_reg, out_pc_reg};

endmodule

// File: sim/tb_top.sv
// Testbench for chip8_alu_branch_unit: directed and random instruction words
// checked against an in-bench model of registers, pc and the return stack.
// Depends on c8ab_pkg and the chip8_alu_branch_unit RTL.
`timescale 1ns / 1ps

module tb_top;

    // Expected result word, one per accepted instruction word
    typedef struct packed {
        logic [c8ab_pkg::PC_W-1:0]   pc;
        logic [c8ab_pkg::BYTE_W-1:0] x_val;
        logic [c8ab_pkg::BYTE_W-1:0] flag;
        logic                        fault;
    } exec_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // op[3:0], reg_x[7:4], reg_y[11:8], imm[23:12]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // pc_value[11:0], x_value[19:12], flag_value[27:20],
                             // stack_fault[28]

    // Shadow machine state, advanced as each word is accepted
    logic [c8ab_pkg::BYTE_W-1:0] vreg [c8ab_pkg::REG_NUM];
    logic [c8ab_pkg::PC_W-1:0]   pc_model;
    logic [c8ab_pkg::PC_W-1:0]   ret_stack [c8ab_pkg::STACK_DEPTH];
    int                          stack_used;

    exec_result_t expected_q[$];
    int           err_count      = 0;
    int           instr_count    = 0;
    int           send_idle_pct  = 0;   // chance per cycle that the sender holds off
    int           recv_stall_pct = 0;   // chance per cycle that m_tready is low
    int           hold_cnt       = 0;   // forced m_tready-low cycles still to run

    chip8_alu_branch_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
        err_count++;
    endtask

    // Execute one instruction on the shadow state and queue its result.
    task automatic exec_model(input c8ab_pkg::op_t op, input logic [3:0] x,
                              input logic [3:0] y,
                              input logic [c8ab_pkg::PC_W-1:0] imm);
        logic [c8ab_pkg::BYTE_W-1:0] vx;
        logic [c8ab_pkg::BYTE_W-1:0] vy;
        logic [c8ab_pkg::BYTE_W-1:0] nn;
        logic [c8ab_pkg::BYTE_W:0]   sum;
        logic                        skip;
        logic                        fault;
        exec_result_t                res;
        vx    = vreg[x];
        vy    = vreg[y];
        nn    = imm[c8ab_pkg::BYTE_W-1:0];
        skip  = 1'b0;
        fault = 1'b0;
        case (op)
            c8ab_pkg::OP_RET: begin
                if (stack_used == 0) begin
                    fault = 1'b1;          // underflow: pc stays
                end else begin
                    stack_used--;
                    pc_model = ret_stack[c8ab_pkg::SA_W'(stack_used)];
                end
            end
            c8ab_pkg::OP_JMP:   pc_model = imm;
            c8ab_pkg::OP_CALL: begin
                if (stack_used >= c8ab_pkg::STACK_DEPTH) begin
                    fault = 1'b1;          // overflow: nothing pushed, pc stays
                end else begin
                    ret_stack[c8ab_pkg::SA_W'(stack_used)] = pc_model;
                    stack_used++;
                    pc_model = imm;
                end
            end
            c8ab_pkg::OP_SKEQI: skip = (vx == nn);
            c8ab_pkg::OP_SKNEI: skip = (vx != nn);
            c8ab_pkg::OP_SKEQR: skip = (vx == vy);
            c8ab_pkg::OP_SETI:  vreg[x] = nn;
            c8ab_pkg::OP_ADDI:  vreg[x] = vx + nn;   // VF untouched
            c8ab_pkg::OP_MOV:   vreg[x] = vy;
            c8ab_pkg::OP_OR:    vreg[x] = vx | vy;
            c8ab_pkg::OP_AND:   vreg[x] = vx & vy;
            c8ab_pkg::OP_XOR:   vreg[x] = vx ^ vy;
            // flag first, then Vx, so Vx wins when x is VF
            c8ab_pkg::OP_ADDC: begin
                sum                      = {1'b0, vx} + {1'b0, vy};
                vreg[c8ab_pkg::FLAG_IDX] = {7'd0, sum[c8ab_pkg::BYTE_W]};
                vreg[x]                  = sum[c8ab_pkg::BYTE_W-1:0];
            end
            c8ab_pkg::OP_SUB: begin
                vreg[c8ab_pkg::FLAG_IDX] = {7'd0, vx >= vy};
                vreg[x]                  = vx - vy;
            end
            c8ab_pkg::OP_SUBN: begin
                vreg[c8ab_pkg::FLAG_IDX] = {7'd0, vy >= vx};
                vreg[x]                  = vy - vx;
            end
            default:  skip = (vx != vy);   // skner
        endcase
        if (skip)
            pc_model = pc_model + 12'd2;   // wraps at 12 bits
        res.pc    = pc_model;
        res.x_val = vreg[x];
        res.flag  = vreg[c8ab_pkg::FLAG_IDX];
        res.fault = fault;
        expected_q.push_back(res);
    endtask

    // Offer one word, with random sender gaps, and wait for the accept edge.
    // tvalid is left high afterwards; the next call or a pause decides it.
    task automatic issue_instr(input c8ab_pkg::op_t op, input logic [3:0] x,
                               input logic [3:0] y,
                               input logic [c8ab_pkg::PC_W-1:0] imm);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {imm, y, x, op};
        do @(posedge aclk); while (!s_tready);
        instr_count++;
        exec_model(op, x, y, imm);
    endtask

    // Drop tvalid and sit until every queued result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    task automatic issue_random_instr();
        c8ab_pkg::op_t             op;
        logic [3:0]                x;
        logic [3:0]                y;
        logic [c8ab_pkg::PC_W-1:0] imm;
        op  = c8ab_pkg::op_t'($urandom_range(0, 15));
        x   = 4'($urandom_range(0, 15));
        y   = 4'($urandom_range(0, 15));
        imm = 12'($urandom_range(0, 4095));
        // steer half the immediate compares onto a match
        if ((op == c8ab_pkg::OP_SKEQI || op == c8ab_pkg::OP_SKNEI) && $urandom_range(0, 1))
            imm[c8ab_pkg::BYTE_W-1:0] = vreg[x];
        if ((op == c8ab_pkg::OP_SKEQR || op == c8ab_pkg::OP_SKNER) &&
            $urandom_range(0, 2) == 0)
            y = x;
        issue_instr(op, x, y, imm);
    endtask

    // Nested calls with random work between them, then a roughly matching
    // number of returns; deep chains run into overflow, extra returns underflow.
    task automatic issue_call_chain();
        int depth;
        int rets;
        depth = $urandom_range(1, c8ab_pkg::STACK_DEPTH + 3);
        rets  = $urandom_range(depth > 2 ? depth - 2 : 0, depth + 1);
        repeat (depth) begin
            issue_instr(c8ab_pkg::OP_CALL, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            if ($urandom_range(0, 2) == 0)
                issue_random_instr();
        end
        repeat (rets) begin
            if ($urandom_range(0, 3) == 0)
                issue_random_instr();
            issue_instr(c8ab_pkg::OP_RET, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
        end
    endtask

    // Fresh state: every register reads zero, the stack is empty
    task automatic test_reset_state();
        issue_instr(c8ab_pkg::OP_SKEQR, 4'd0, 4'd14, 12'h000);
        issue_instr(c8ab_pkg::OP_SKEQI, 4'd7, 4'd0, 12'hF00);    // upper imm bits ignored
        issue_instr(c8ab_pkg::OP_RET, 4'd0, 4'd0, 12'h000);      // underflow
    endtask

    task automatic test_byte_ops();
        issue_instr(c8ab_pkg::OP_SETI, 4'd1, 4'd0, 12'hFFF);
        issue_instr(c8ab_pkg::OP_SETI, 4'd2, 4'd0, 12'h001);
        issue_instr(c8ab_pkg::OP_ADDI, 4'd1, 4'd0, 12'hEFF);     // wraps, VF untouched
        issue_instr(c8ab_pkg::OP_MOV, 4'd3, 4'd1, 12'h000);
        issue_instr(c8ab_pkg::OP_OR, 4'd3, 4'd2, 12'h000);
        issue_instr(c8ab_pkg::OP_AND, 4'd3, 4'd1, 12'h000);
        issue_instr(c8ab_pkg::OP_XOR, 4'd5, 4'd1, 12'h000);
        issue_instr(c8ab_pkg::OP_ADDI, 4'd15, 4'd0, 12'h0FF);
    endtask

    task automatic test_flag_ops();
        issue_instr(c8ab_pkg::OP_ADDC, 4'd1, 4'd1, 12'h000);     // carry out
        issue_instr(c8ab_pkg::OP_ADDC, 4'd2, 4'd2, 12'h000);     // no carry
        issue_instr(c8ab_pkg::OP_SUB, 4'd2, 4'd1, 12'h000);      // borrow
        issue_instr(c8ab_pkg::OP_SUB, 4'd3, 4'd3, 12'h000);      // equal: no borrow, zero
        issue_instr(c8ab_pkg::OP_SUBN, 4'd2, 4'd1, 12'h000);
        issue_instr(c8ab_pkg::OP_ADDC, 4'd15, 4'd1, 12'h000);    // VF as destination
        issue_instr(c8ab_pkg::OP_SUB, 4'd15, 4'd2, 12'h000);
        issue_instr(c8ab_pkg::OP_SUBN, 4'd15, 4'd1, 12'h000);
    endtask

    task automatic test_branches();
        issue_instr(c8ab_pkg::OP_JMP, 4'd0, 4'd0, 12'hFFE);
        issue_instr(c8ab_pkg::OP_SKNEI, 4'd0, 4'd0, 12'h001);    // skip wraps to 0x000
        issue_instr(c8ab_pkg::OP_JMP, 4'd0, 4'd0, 12'hFFF);
        issue_instr(c8ab_pkg::OP_SKEQR, 4'd5, 4'd5, 12'h000);    // skip wraps to 0x001
        issue_instr(c8ab_pkg::OP_SKNER, 4'd1, 4'd2, 12'h000);
        issue_instr(c8ab_pkg::OP_SKNEI, 4'd0, 4'd0, 12'h000);    // no skip
        issue_instr(c8ab_pkg::OP_CALL, 4'd0, 4'd0, 12'hABC);
        issue_instr(c8ab_pkg::OP_CALL, 4'd0, 4'd0, 12'h123);
        issue_instr(c8ab_pkg::OP_RET, 4'd0, 4'd0, 12'h000);
        issue_instr(c8ab_pkg::OP_RET, 4'd0, 4'd0, 12'h000);
    endtask

    // m_tready held low for a long stretch while the sender keeps offering
    // calls, so the block backs up into s_tready. The stack is filled past
    // its depth and then emptied past zero.
    task automatic test_output_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (stack_used > 0)
            issue_instr(c8ab_pkg::OP_RET, 4'd0, 4'd0, 12'h000);
        hold_cnt = 200;
        repeat (c8ab_pkg::STACK_DEPTH + 2)
            issue_instr(c8ab_pkg::OP_CALL, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
        repeat (c8ab_pkg::STACK_DEPTH + 2)
            issue_instr(c8ab_pkg::OP_RET, 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
        pause_until_drained();
    endtask

    task automatic test_random_stream(input int n_words, input int send_pct,
                                      input int recv_pct);
        int stop_at;
        stop_at        = instr_count + n_words;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (instr_count < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                issue_call_chain();
            else
                issue_random_instr();
        end
    endtask

    // Receiver: random m_tready, overridden by a forced hold-off
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt = hold_cnt - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker: every accepted result word against the oldest expectation
    always @(posedge aclk) begin
        exec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[11:0] !== want.pc)
                    report_mismatch("pc_value", 32'(m_tdata[11:0]), 32'(want.pc));
                if (m_tdata[19:12] !== want.x_val)
                    report_mismatch("x_value", 32'(m_tdata[19:12]), 32'(want.x_val));
                if (m_tdata[27:20] !== want.flag)
                    report_mismatch("flag_value", 32'(m_tdata[27:20]), 32'(want.flag));
                if (m_tdata[28] !== want.fault)
                    report_mismatch("stack_fault", 32'(m_tdata[28]), 32'(want.fault));
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        foreach (vreg[i])
            vreg[i] = '0;
        foreach (ret_stack[i])
            ret_stack[i] = '0;
        pc_model   = '0;
        stack_used = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_byte_ops();
        test_flag_ops();
        test_branches();
        test_output_stall();
        test_random_stream(280, 0, 0);
        test_random_stream(270, 88, 0);
        test_random_stream(270, 0, 88);
        test_random_stream(270, 10, 10);

        // drain, then leave room for any stray late word
        pause_until_drained();
        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
